// ===== src/ssd_pkg.sv =====
// Types, constants and microcode table for the sample standard deviation block.
`default_nettype none

package ssd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int CNT_W       = 17;
   localparam int SUM_W       = 33;
   localparam int SQSUM_W     = 47;
   localparam int SQP_W       = 31;
   localparam int ABS_W       = 32;
   localparam int PROD_W      = 64;
   localparam int DEN_W       = 32;
   localparam int QUO_W       = 48;
   localparam int SD_W        = 24;
   localparam int STAT_W      = 2;
   localparam int PC_W        = 4;
   localparam int LOOP_W      = 6;
   localparam int DIV_STEPS   = 48;
   localparam int SQRT_STEPS  = 24;
   localparam int MIN_COUNT   = 2;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - SD_W - STAT_W;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK  = 2'd0,
      STAT_FEW = 2'd1,
      STAT_OVF = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ABS,
      OP_LOAD_SQ,
      OP_LOAD_NUM,
      OP_ADD_HI,
      OP_LOAD_DEN,
      OP_SUB,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_EMIT_OK,
      OP_EMIT_OVF,
      OP_EMIT_FEW
   } op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQ,
      MUL_NLO,
      MUL_NHI,
      MUL_DEN
   } mul_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_LOAD,
      BR_LOOP,
      BR_IF_OVF,
      BR_IF_FEW,
      BR_DONE
   } br_type;

   typedef struct packed {
      op_type              op;
      mul_type             mul;
      br_type              br;
      logic [PC_W-1:0]     target;
      logic [LOOP_W-1:0]   loop_cnt;
   } cw_type;

   typedef struct packed {
      logic    en;
      op_type  op;
      mul_type mul;
   } ctl_type;

   typedef struct packed {
      logic ovf;
      logic few;
   } flags_type;

   localparam logic [PC_W-1:0] PC_EMIT_OVF = 4'd12;
   localparam logic [PC_W-1:0] PC_EMIT_FEW = 4'd13;
   localparam logic [PC_W-1:0] PC_LAST     = 4'd13;

   localparam logic [LOOP_W-1:0] DIV_LOAD  = LOOP_W'(DIV_STEPS - 1);
   localparam logic [LOOP_W-1:0] SQRT_LOAD = LOOP_W'(SQRT_STEPS - 1);

   // Multiplier operands are picked one step ahead of the op that consumes the product.
   function automatic cw_type ucode_rom(input logic [PC_W-1:0] pc);
      cw_type cw;
      case (pc)
         4'd0:    cw = '{OP_ABS,       MUL_NONE, BR_IF_OVF, PC_EMIT_OVF, '0};
         4'd1:    cw = '{OP_NOP,       MUL_SQ,   BR_IF_FEW, PC_EMIT_FEW, '0};
         4'd2:    cw = '{OP_LOAD_SQ,   MUL_NLO,  BR_NEXT,   '0,          '0};
         4'd3:    cw = '{OP_LOAD_NUM,  MUL_NHI,  BR_NEXT,   '0,          '0};
         4'd4:    cw = '{OP_ADD_HI,    MUL_DEN,  BR_NEXT,   '0,          '0};
         4'd5:    cw = '{OP_LOAD_DEN,  MUL_NONE, BR_NEXT,   '0,          '0};
         4'd6:    cw = '{OP_SUB,       MUL_NONE, BR_NEXT,   '0,          '0};
         4'd7:    cw = '{OP_DIV_INIT,  MUL_NONE, BR_LOAD,   '0,          DIV_LOAD};
         4'd8:    cw = '{OP_DIV_STEP,  MUL_NONE, BR_LOOP,   '0,          '0};
         4'd9:    cw = '{OP_SQRT_INIT, MUL_NONE, BR_LOAD,   '0,          SQRT_LOAD};
         4'd10:   cw = '{OP_SQRT_STEP, MUL_NONE, BR_LOOP,   '0,          '0};
         4'd11:   cw = '{OP_EMIT_OK,   MUL_NONE, BR_DONE,   '0,          '0};
         4'd12:   cw = '{OP_EMIT_OVF,  MUL_NONE, BR_DONE,   '0,          '0};
         4'd13:   cw = '{OP_EMIT_FEW,  MUL_NONE, BR_DONE,   '0,          '0};
         default: cw = '{OP_NOP,       MUL_NONE, BR_DONE,   '0,          '0};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ===== src/ssd_seq.sv =====
// Microcode sequencer: step counter, loop counter and branch logic over the control table.
`default_nettype none

module ssd_seq
   import ssd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   input  wire logic      hold,
   input  wire flags_type flags,
   output ctl_type        ctl,
   output logic           busy
);

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [LOOP_W-1:0] iter_ff, iter_in;
   cw_type            cw;
   logic              emit_step;
   logic              step_en;

   assign cw        = ucode_rom(pc_ff);
   assign emit_step = cw.op inside {OP_EMIT_OK, OP_EMIT_OVF, OP_EMIT_FEW};
   // an emit waits while the output register is full and not being taken
   assign step_en   = busy_ff && !(emit_step && hold);

   assign ctl.en  = step_en;
   assign ctl.op  = cw.op;
   assign ctl.mul = cw.mul;
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         iter_ff <= iter_in;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      iter_in = iter_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (step_en) begin
         case (cw.br)
            BR_NEXT: pc_in = pc_ff + 1'b1;
            BR_LOAD: begin
               pc_in   = pc_ff + 1'b1;
               iter_in = cw.loop_cnt;
            end
            BR_LOOP: begin
               if (iter_ff != '0) begin
                  iter_in = iter_ff - 1'b1;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            BR_IF_OVF: pc_in = flags.ovf ? cw.target : pc_ff + 1'b1;
            BR_IF_FEW: pc_in = flags.few ? cw.target : pc_ff + 1'b1;
            BR_DONE: begin
               busy_in = 1'b0;
               pc_in   = '0;
            end
            default: begin
               busy_in = 1'b0;
               pc_in   = '0;
            end
         endcase
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("program started while busy");

   a_start_pc: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && pc_ff == '0)
      else $error("program did not begin at step zero");

   a_loop_stays: assert property (@(posedge clock) disable iff (reset)
      step_en && cw.br == BR_LOOP && iter_ff != '0 |=> $stable(pc_ff))
      else $error("loop left before its count ran out");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= PC_LAST)
      else $error("step counter outside program");

endmodule

`default_nettype wire

// ===== src/ssd_dp.sv =====
// Datapath: accumulators, shared multiplier, restoring divider and square root registers.
`default_nettype none

module ssd_dp
   import ssd_pkg::*;
#(
   parameter int MAX_SAMPLES = 65536
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_xfer,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire ctl_type             ctl,
   output flags_type                flags,
   output logic                     emit,
   output logic [SD_W-1:0]          std_dev,
   output status_type               status
);

   // accumulation state
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQSUM_W-1:0] sqsum_ff, sqsum_in;
   logic               ovf_ff, ovf_in;
   logic [SQP_W-1:0]   sqp_ff, sqp_in;
   logic               sqp_vld_ff, sqp_vld_in;

   // final computation registers
   logic [ABS_W-1:0]   abs_ff, abs_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  sq_ff, sq_in;
   logic [PROD_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   dq_ff, dq_in;
   logic [SD_W-1:0]    root_ff, root_in;

   logic [ABS_W-1:0]   mul_a, mul_b;
   logic [CNT_W-1:0]   cnt_m1;
   logic signed [2*SAMPLE_W-1:0] samp_sq;
   logic [DEN_W:0]     div_trial;
   logic [DEN_W-1:0]   sqrt_cur;
   logic [DEN_W-1:0]   sqrt_trial;
   logic               room;

   assign room      = count_ff < CNT_W'(MAX_SAMPLES);
   assign samp_sq   = $signed(sample) * $signed(sample);
   assign cnt_m1    = count_ff - 1'b1;
   assign div_trial = {rem_ff, dq_ff[QUO_W-1]};
   assign sqrt_cur  = {rem_ff[DEN_W-3:0], dq_ff[QUO_W-1:QUO_W-2]};
   assign sqrt_trial = {{(DEN_W-SD_W-2){1'b0}}, root_ff, 2'b01};

   assign flags.ovf = ovf_ff;
   assign flags.few = count_ff < CNT_W'(MIN_COUNT);

   always_comb begin
      case (ctl.mul)
         MUL_SQ: begin
            mul_a = abs_ff;
            mul_b = abs_ff;
         end
         MUL_NLO: begin
            mul_a = ABS_W'(count_ff);
            mul_b = sqsum_ff[ABS_W-1:0];
         end
         MUL_NHI: begin
            mul_a = ABS_W'(count_ff);
            mul_b = ABS_W'(sqsum_ff[SQSUM_W-1:ABS_W]);
         end
         MUL_DEN: begin
            mul_a = ABS_W'(count_ff);
            mul_b = ABS_W'(cnt_m1);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = {{(PROD_W-ABS_W){1'b0}}, mul_a} * {{(PROD_W-ABS_W){1'b0}}, mul_b};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_ff     <= '0;
         sqsum_ff   <= '0;
         ovf_ff     <= 1'b0;
         sqp_vld_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         sqsum_ff   <= sqsum_in;
         ovf_ff     <= ovf_in;
         sqp_vld_ff <= sqp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sqp_ff  <= sqp_in;
      abs_ff  <= abs_in;
      prod_ff <= prod_in;
      sq_ff   <= sq_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      root_ff <= root_in;
   end

   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      sqsum_in   = sqsum_ff;
      ovf_in     = ovf_ff;
      sqp_in     = sqp_ff;
      sqp_vld_in = 1'b0;
      abs_in     = abs_ff;
      sq_in      = sq_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      root_in    = root_ff;
      emit       = 1'b0;
      std_dev    = '0;
      status     = STAT_OK;

      // square of a sample is registered at its transfer and added in the cycle after
      if (sqp_vld_ff) begin
         sqsum_in = sqsum_ff + SQSUM_W'(sqp_ff);
      end

      if (in_xfer) begin
         if (room) begin
            count_in   = count_ff + 1'b1;
            sum_in     = sum_ff + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
            sqp_in     = SQP_W'(samp_sq);
            sqp_vld_in = 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (ctl.en) begin
         case (ctl.op)
            OP_ABS: begin
               abs_in = sum_ff[SUM_W-1] ? ABS_W'(-sum_ff) : sum_ff[ABS_W-1:0];
            end
            OP_LOAD_SQ:  sq_in  = prod_ff;
            OP_LOAD_NUM: num_in = prod_ff;
            OP_ADD_HI: begin
               num_in = num_ff + {prod_ff[PROD_W-ABS_W-1:0], {ABS_W{1'b0}}};
            end
            OP_LOAD_DEN: den_in = prod_ff[DEN_W-1:0];
            OP_SUB:      num_in = (num_ff >= sq_ff) ? num_ff - sq_ff : '0;
            OP_DIV_INIT: begin
               // upper half is already below the divisor since the quotient fits 48 bits
               rem_in = num_ff[PROD_W-1:PROD_W-DEN_W];
               dq_in  = {num_ff[PROD_W-DEN_W-1:0], {(QUO_W-(PROD_W-DEN_W)){1'b0}}};
            end
            OP_DIV_STEP: begin
               if (div_trial >= {1'b0, den_ff}) begin
                  rem_in = DEN_W'(div_trial - {1'b0, den_ff});
                  dq_in  = {dq_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_in = div_trial[DEN_W-1:0];
                  dq_in  = {dq_ff[QUO_W-2:0], 1'b0};
               end
            end
            OP_SQRT_INIT: begin
               rem_in  = '0;
               root_in = '0;
            end
            OP_SQRT_STEP: begin
               dq_in = {dq_ff[QUO_W-3:0], 2'b00};
               if (sqrt_cur >= sqrt_trial) begin
                  rem_in  = sqrt_cur - sqrt_trial;
                  root_in = {root_ff[SD_W-2:0], 1'b1};
               end else begin
                  rem_in  = sqrt_cur;
                  root_in = {root_ff[SD_W-2:0], 1'b0};
               end
            end
            OP_EMIT_OK, OP_EMIT_OVF, OP_EMIT_FEW: begin
               emit      = 1'b1;
               std_dev   = (ctl.op == OP_EMIT_OK) ? root_ff : '0;
               status    = (ctl.op == OP_EMIT_OK)  ? STAT_OK :
                           (ctl.op == OP_EMIT_OVF) ? STAT_OVF : STAT_FEW;
               count_in  = '0;
               sum_in    = '0;
               sqsum_in  = '0;
               ovf_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/sample_standard_deviation_top.sv =====
// A sample without tlast is accumulated, one transfer per cycle while no program
// runs. A closing sample starts an 82-step program (8 setup steps, 48 divide
// steps, 25 square root steps, 1 output step). Sets with an overflowed count jump
// to their output step from the first step, sets with fewer than two from the second.
// req_tready is low while the program runs; the output register frees the
// program from a stalled rsp side until the next result. Sync reset clears all sets.
`default_nettype none

module sample_standard_deviation_top
   import ssd_pkg::*;
#(
   parameter int MAX_SAMPLES = 65536
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [15:0] sample
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata   // [23:0] std_dev, [25:24] status
);

   logic       busy;
   logic       in_xfer;
   logic       start;
   logic       emit;
   ctl_type    ctl;
   flags_type  flags;
   logic [SD_W-1:0] dp_std_dev;
   status_type dp_status;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [SD_W-1:0] rsp_sd_ff, rsp_sd_in;
   status_type      rsp_stat_ff, rsp_stat_in;

   assign req_tready = !busy;
   assign in_xfer    = req_tvalid && req_tready;
   assign start      = in_xfer && req_tlast;

   ssd_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .hold  (rsp_valid_ff && !rsp_tready),
      .flags (flags),
      .ctl   (ctl),
      .busy  (busy)
   );

   ssd_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .in_xfer (in_xfer),
      .sample  (req_tdata[SAMPLE_W-1:0]),
      .ctl     (ctl),
      .flags   (flags),
      .emit    (emit),
      .std_dev (dp_std_dev),
      .status  (dp_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sd_ff   <= rsp_sd_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sd_in    = rsp_sd_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_sd_in    = dp_std_dev;
         rsp_stat_in  = dp_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_stat_ff, rsp_sd_ff};

endmodule

`default_nettype wire
